>>> hdl/tlru_pkg.sv
`default_nettype none
package tlru_pkg;
    localparam int ENTRIES   = 16;
    localparam int PROCESSES = 8;
    localparam int PAGE_BITS = 28;
    localparam int EW = $clog2(ENTRIES);
    localparam int SW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int QD = 2;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    localparam logic [1:0] OC_MISS    = 2'd0;
    localparam logic [1:0] OC_REFILL  = 2'd1;
    localparam logic [1:0] OC_HIT     = 2'd2;
    localparam logic [1:0] OC_INVDONE = 2'd3;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INVAL  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [27:0] page_number;
        logic [2:0]  process_id;
    } t_req;

    typedef struct packed {
        logic [1:0] outcome;
        logic [4:0] invalidated_count;
    } t_rsp;

    typedef struct packed {
        logic                 kind;
        logic                 per_proc;
        logic [SW-1:0]        set;
        logic [PAGE_BITS-1:0] page;
        logic [2:0]           pid;
    } t_cmd;
endpackage
`default_nettype wire

>>> hdl/tlb_lru_asid_lookup_top.sv
// Fully associative LRU TLB with process tags (per-process mode instead gives each
// process its own set). With queue and back end idle, an accepted item is popped
// into the back end, which reads the set row, updates it, writes it back and
// registers the result; it takes no new item until that row is written back.
// A two deep queue decouples the front; busy is high while it is full. The
// result strobe lasts one cycle and cannot be stalled.
`default_nettype none
module tlb_lru_asid_lookup_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_wdata,
    input  wire logic           start,
    output logic                busy,
    input  wire tlru_pkg::t_req i_req,
    output logic                o_strobe,
    output tlru_pkg::t_rsp      o_rsp
);
    import tlru_pkg::*;
    logic w_push, w_full, w_valid, w_pop;
    t_cmd w_cmd, w_qcmd;

    tlru_front u_front (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .start, .busy,
        .i_req, .o_push(w_push), .o_cmd(w_cmd), .i_full(w_full));
    tlru_queue u_queue (.i_clk, .i_rst_n, .i_push(w_push), .i_cmd(w_cmd),
        .o_full(w_full), .o_valid(w_valid), .o_cmd(w_qcmd), .i_pop(w_pop));
    tlru_back u_back (.i_clk, .i_rst_n, .i_valid(w_valid), .i_cmd(w_qcmd),
        .o_pop(w_pop), .o_strobe, .o_rsp);
endmodule
`default_nettype wire

>>> hdl/tlru_front.sv
`default_nettype none
module tlru_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          start,
    output logic               busy,
    input  wire tlru_pkg::t_req i_req,
    output logic               o_push,
    output tlru_pkg::t_cmd     o_cmd,
    input  wire logic          i_full
);
    import tlru_pkg::*;
    logic r_mode;
    logic [5:0] w_set6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign busy   = i_full;
    assign o_push = start && !i_full;
    assign w_set6 = 6'(i_req.process_id) % 6'(PROCESSES);
    always_comb begin
        o_cmd.kind     = i_req.kind;
        o_cmd.per_proc = r_mode;
        o_cmd.set      = r_mode ? w_set6[SW-1:0] : '0;
        o_cmd.page     = i_req.page_number[PAGE_BITS-1:0];
        o_cmd.pid      = i_req.process_id;
    end
endmodule
`default_nettype wire

>>> hdl/tlru_queue.sv
`default_nettype none
module tlru_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tlru_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output tlru_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);
    import tlru_pkg::*;
    t_cmd r_mem [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == QAW'(QD - 1)) ? '0 : r_wp + QAW'(1);
            if (i_pop)  r_rp <= (r_rp == QAW'(QD - 1)) ? '0 : r_rp + QAW'(1);
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QD)) else $error("queue count overflow");
    ap_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push while full");
    ap_no_unf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop while empty");
endmodule
`default_nettype wire

>>> hdl/tlru_back.sv
`default_nettype none
module tlru_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tlru_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_strobe,
    output tlru_pkg::t_rsp      o_rsp
);
    import tlru_pkg::*;
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [2:0]           pid;
        logic                 vld;
        logic [EW-1:0]        rank;
    } t_ent;
    typedef logic [ENTRIES-1:0][$bits(t_ent)-1:0] t_row;
    typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} t_st;

    t_row r_mem [PROCESSES];
    t_row r_row, n_row;
    t_st  r_st;
    t_cmd r_cmd;
    logic [PROCESSES-1:0] r_init;
    logic r_strobe;
    t_rsp r_rsp, n_rsp;

    // one row per set: read, update, write back
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid) r_row <= r_mem[i_cmd.set];
        if (r_st == S_WRITE) r_mem[r_cmd.set] <= n_row;
    end

    // ranks within a set are a permutation, so the least recent has the top rank
    always_comb begin
        t_ent e, s;
        logic [ENTRIES-1:0] m;
        logic [ENTRIES-1:0][EW-1:0] rk;
        logic found, win;
        logic [EW-1:0] bi, br, li, lr;
        logic [5:0] cnt;
        t_row row;
        found = 1'b0; bi = '0; br = '0; li = '0; lr = EW'(ENTRIES - 1); cnt = '0;
        m = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_init[r_cmd.set]) e = t_ent'(r_row[i]);
            else e = '{page: '0, pid: '0, vld: 1'b0, rank: EW'(i)};
            row[i] = e;
            rk[i] = e.rank;
            m[i] = (e.page == r_cmd.page) && (r_cmd.per_proc || e.pid == r_cmd.pid);
            if (m[i] && e.vld) cnt = cnt + 6'd1;
            if (e.rank == lr) li = EW'(i);
        end
        for (int i = 0; i < ENTRIES; i++) begin
            win = m[i];
            for (int j = 0; j < ENTRIES; j++)
                if (m[j] && rk[j] < rk[i]) win = 1'b0;
            if (win) begin
                found = 1'b1; bi = EW'(i); br = rk[i];
            end
        end
        n_row = row;
        n_rsp = '0;
        if (r_cmd.kind == KIND_INVAL) begin
            for (int i = 0; i < ENTRIES; i++) begin
                s = t_ent'(row[i]);
                if (m[i]) s.vld = 1'b0;
                n_row[i] = s;
            end
            n_rsp.outcome = OC_INVDONE;
            n_rsp.invalidated_count = (cnt > 6'd31) ? 5'd31 : cnt[4:0];
        end else begin
            if (!found) begin
                bi = li; br = lr;
            end
            s = t_ent'(row[bi]);
            n_rsp.outcome = !found ? OC_MISS : (s.vld ? OC_HIT : OC_REFILL);
            for (int i = 0; i < ENTRIES; i++) begin
                s = t_ent'(row[i]);
                if (s.rank < br) s.rank = s.rank + EW'(1);
                if (EW'(i) == bi) begin
                    s.rank = '0; s.vld = 1'b1;
                    if (!found) begin
                        s.page = r_cmd.page; s.pid = r_cmd.pid;
                    end
                end
                n_row[i] = s;
            end
        end
    end

    assign o_pop    = (r_st == S_IDLE) && i_valid;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_strobe <= 1'b0; r_init <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd; r_st <= S_READ;
                end
                S_READ: begin
                    r_st <= S_WRITE;
                end
                S_WRITE: begin
                    r_rsp <= n_rsp; r_strobe <= 1'b1;
                    r_init[r_cmd.set] <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_st == S_READ) else $error("pop not followed by read");
    ap_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_WRITE |=> o_strobe) else $error("missing result");
    ap_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$past(o_strobe)) else $error("double result");
endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import tlru_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 1630;
    localparam int ROWS           = ENTRIES * PROCESSES;

    class tlb_scoreboard;
        logic [PAGE_BITS-1:0] page_tag [ROWS];
        logic [2:0]           pid_tag  [ROWS];
        bit                   valid    [ROWS];
        int                   rank     [ROWS];
        bit                   per_proc;
        t_rsp                 pending[$];
        int                   errors;

        function void clear();
            for (int s = 0; s < PROCESSES; s++)
                for (int i = 0; i < ENTRIES; i++) begin
                    page_tag[s*ENTRIES+i] = '0;
                    pid_tag[s*ENTRIES+i]  = '0;
                    valid[s*ENTRIES+i]    = 0;
                    rank[s*ENTRIES+i]     = i;
                end
            per_proc = 0;
            errors = 0;
        endfunction

        function void make_recent(int base, int idx);
            int old;
            old = rank[base+idx];
            for (int i = 0; i < ENTRIES; i++)
                if (rank[base+i] < old) rank[base+i]++;
            rank[base+idx] = 0;
        endfunction

        function void note_beat(t_req r);
            logic [PAGE_BITS-1:0] pg;
            int   base, cnt, hit, hit_rank, lru;
            bit   m;
            t_rsp x;
            pg = r.page_number[PAGE_BITS-1:0];
            base = per_proc ? (int'(r.process_id) % PROCESSES) * ENTRIES : 0;
            x = '0;
            if (r.kind == KIND_INVAL) begin
                cnt = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    m = page_tag[base+i] == pg && (per_proc || pid_tag[base+i] == r.process_id);
                    if (m) begin
                        if (valid[base+i]) cnt++;
                        valid[base+i] = 0;
                    end
                end
                x.outcome = OC_INVDONE;
                x.invalidated_count = cnt > 31 ? 5'd31 : 5'(cnt);
            end else begin
                hit = -1;
                hit_rank = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    m = page_tag[base+i] == pg && (per_proc || pid_tag[base+i] == r.process_id);
                    if (m && (hit < 0 || rank[base+i] < hit_rank)) begin
                        hit = i;
                        hit_rank = rank[base+i];
                    end
                end
                if (hit >= 0) begin
                    x.outcome = valid[base+hit] ? OC_HIT : OC_REFILL;
                    valid[base+hit] = 1;
                    make_recent(base, hit);
                end else begin
                    lru = 0;
                    for (int i = 1; i < ENTRIES; i++)
                        if (rank[base+i] > rank[base+lru]) lru = i;
                    page_tag[base+lru] = pg;
                    pid_tag[base+lru]  = r.process_id;
                    valid[base+lru]    = 1;
                    make_recent(base, lru);
                    x.outcome = OC_MISS;
                end
            end
            pending.push_back(x);
        endfunction

        function void check_beat(t_rsp a);
            t_rsp e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.outcome !== e.outcome) begin
                $display("%0t: outcome expected %0d actual %0d", $time, e.outcome, a.outcome);
                errors++;
            end
            if (a.invalidated_count !== e.invalidated_count) begin
                $display("%0t: count expected %0d actual %0d", $time,
                         e.invalidated_count, a.invalidated_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic i_cfg_wdata = 0;
    logic start = 0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_rsp o_rsp;

    tlb_scoreboard sb;
    int  idle_cycles = 0;
    bit  no_gaps = 0;
    logic [PAGE_BITS-1:0] pool [8];

    tlb_lru_asid_lookup_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy), .i_req(i_req), .o_strobe(o_strobe), .o_rsp(o_rsp)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_beat(o_rsp);
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // start stays high after a beat; only a gap in the next send or drain takes it down
    task automatic send(logic k, logic [27:0] pg, logic [2:0] pid);
        t_req r;
        r.kind = k;
        r.page_number = pg;
        r.process_id = pid;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start <= 1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_beat(r);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mode(logic v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.per_proc = v;
        i_cfg_we <= 0;
    endtask

    task automatic random_item();
        logic [27:0] pg;
        if ($urandom_range(0, 9) < 8) pg = pool[$urandom_range(0, 7)];
        else pg = 28'($urandom);
        if ($urandom_range(0, 4) == 0)
            send(KIND_INVAL, pg, 3'($urandom_range(0, 7)));
        else
            send(KIND_LOOKUP, pg, 3'($urandom_range(0, 7)));
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // reset entries: page 0 refills, then extremes
        send(KIND_LOOKUP, 28'h0, 3'd0);
        send(KIND_LOOKUP, 28'h0, 3'd0);
        send(KIND_INVAL, 28'h0, 3'd0);
        send(KIND_INVAL, 28'h0, 3'd0);
        send(KIND_LOOKUP, 28'hFFFFFFF, 3'd7);
        send(KIND_LOOKUP, 28'hFFFFFFF, 3'd0);
        send(KIND_LOOKUP, 28'hFFFFFFF, 3'd7);
        for (int i = 0; i < 17; i++) send(KIND_LOOKUP, 28'h5A5, 3'(i));
        set_mode(1);
        send(KIND_LOOKUP, 28'hFFFFFFF, 3'd7);
        send(KIND_INVAL, 28'h5A5, 3'd3);
        send(KIND_INVAL, 28'h0, 3'd5);
        for (int ph = 0; ph < 6; ph++) begin
            for (int p = 0; p < 8; p++)
                pool[p] = (ph % 2) ? 28'($urandom_range(0, 20)) : 28'($urandom);
            if (ph == 5) no_gaps = 1;
            for (int n = 0; n < N_RANDOM / 6; n++) random_item();
            set_mode(1'(ph % 2));
        end
        drain();
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
